/* design/bbe_pkg.sv */
// Shared constants, codes and transaction types of the 3x3 boundary extraction block.
`timescale 1ns / 1ps

package bbe_pkg;

    // Frame limits and the widths that follow from them.
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int IN_ROW_W     = ROW_W + 1;
    localparam int BLK_DEPTH    = 2 * MAX_WIDTH;

    // Register and pixel widths.
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Register reset values.
    localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = CFG_HEIGHT_W'(480);

    // A removed interior pixel is painted full white.
    localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;
    localparam logic [PIX_W-1:0] WHITE_PIX = {CH_MAX, CH_MAX, CH_MAX};

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Input transaction.
    typedef struct packed {
        logic            op;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
        logic            frame_end;
    } t_out_item;

    // One window column: black bits (bit 0 top, bit 1 middle, bit 2 bottom) and the
    // middle row pixel of that column.
    typedef struct packed {
        logic [2:0]       blk;
        logic [PIX_W-1:0] pix;
    } t_col;

    // Which sides of the output pixel's neighbourhood lie outside the frame.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edges;

    // Control carried alongside the line memory read.
    typedef struct packed {
        logic   has_out;
        logic   last;
        logic   bot;
        t_edges edges;
    } t_stage;

endpackage

/* design/bbe_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bbe_cell.sv */
// One window cell: holds a single 3x3 window column and passes it on when shifted.
`timescale 1ns / 1ps

module bbe_cell import bbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_clr,
    input  t_col i_col,
    output t_col o_col
);

    t_col r_col;

    // Clearing wins over shifting so that a new frame starts from an empty window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_clr) begin
            r_col <= '0;
        end else if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

/* design/bbe_window.sv */
// 3x3 window built from a chain of column cells, with the interior test on the shifted window.
`timescale 1ns / 1ps

module bbe_window import bbe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_clear,
    input  t_col             i_col,
    input  t_edges           i_edges,
    output logic [PIX_W-1:0] o_pix
);

    t_col       near_col;
    t_col       far_col;
    logic [2:0] col_blk [3];
    logic [8:0] hits;

    // The newest stored column sits next to the incoming one; the older one follows it.
    bbe_cell u_cell_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_shift),
        .i_clr   (i_clear),
        .i_col   (i_col),
        .o_col   (near_col)
    );

    bbe_cell u_cell_far (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_shift),
        .i_clr   (i_clear),
        .i_col   (near_col),
        .o_col   (far_col)
    );

    // Window as it stands once this column has shifted in: left, centre, right.
    assign col_blk[0] = far_col.blk;
    assign col_blk[1] = near_col.blk;
    assign col_blk[2] = i_col.blk;

    // Each tap counts when its pixel is black or it lies outside the frame.
    always_comb begin
        for (int dc = 0; dc < 3; dc++) begin
            for (int dr = 0; dr < 3; dr++) begin
                hits[dr*3 + dc] = col_blk[dc][dr]
                    || (dr == 0 && i_edges.top) || (dr == 2 && i_edges.bottom)
                    || (dc == 0 && i_edges.left) || (dc == 2 && i_edges.right);
            end
        end
    end

    // A pixel with a fully black neighbourhood is an interior pixel and turns white.
    assign o_pix = (&hits) ? WHITE_PIX : near_col.pix;

endmodule

/* design/binary_boundary_extract_3x3.sv */
// Top level of the 3x3 binary boundary extraction block.
// The result for a pixel leaves image_width + 1 input transactions after it was taken;
// the result that a transaction releases passes through the memory stage and then the output
// buffer before it is presented, and the memory stage holds while the output buffer is full.
// Throughput is one transaction per cycle while the output buffer has a free entry.
// Reset gives a 640 x 480 frame with all position counters and the window cleared;
// the line memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module binary_boundary_extract_3x3 import bbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers, raw and clamped.
    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic [CFG_WIDTH_W-1:0]  r_eff_w;
    logic [CFG_HEIGHT_W-1:0] r_eff_h;

    // Frame position counters.
    logic [COL_W-1:0]    r_in_col,  n_in_col;
    logic [IN_ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0]    r_out_row, n_out_row;

    // Stage waiting on the line memory read.
    logic   r_s1_valid, n_s1_valid;
    t_stage r_s1,       n_s1;

    // Two-entry output buffer.
    t_out_item r_head, r_skid;
    logic      r_head_valid, r_skid_valid;

    logic              cfg_wr;
    t_reg_idx          reg_idx;
    logic [CFG_WIDTH_W-1:0]  wr_w;
    logic [CFG_HEIGHT_W-1:0] wr_h;
    logic              in_acc;
    logic              s1_adv;
    logic              pop;
    logic              push;
    logic              in_frame;
    logic [PIX_W-1:0]  pix;
    logic              bot;
    logic              has_out;
    logic              in_col_wrap;
    logic              out_last;
    t_edges            edges;
    logic [PIX_W-1:0]  row_rdata;
    logic [0:0]        blk_rdata;
    t_col              new_col;
    logic              win_clear;
    logic [PIX_W-1:0]  win_pix;
    t_out_item         push_item;

    // Configuration port decode.
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1]);
    assign wr_w    = pwdata[CFG_WIDTH_W-1:0];
    assign wr_h    = pwdata[CFG_HEIGHT_W-1:0];
    assign pready  = 1'b1;

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    // Register writes; the clamped copies feed the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_eff_w  <= RESET_WIDTH;
            r_eff_h  <= RESET_HEIGHT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH: begin
                    r_width <= wr_w;
                    if (wr_w == '0) begin
                        r_eff_w <= CFG_WIDTH_W'(1);
                    end else if (wr_w > CFG_WIDTH_W'(MAX_WIDTH)) begin
                        r_eff_w <= CFG_WIDTH_W'(MAX_WIDTH);
                    end else begin
                        r_eff_w <= wr_w;
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= wr_h;
                    if (wr_h == '0) begin
                        r_eff_h <= CFG_HEIGHT_W'(1);
                    end else if (wr_h > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
                        r_eff_h <= CFG_HEIGHT_W'(MAX_HEIGHT);
                    end else begin
                        r_eff_h <= wr_h;
                    end
                end
                default: begin
                    r_width <= r_width;
                end
            endcase
        end
    end

    // Handshake: the memory stage moves on whenever the output buffer has a free entry.
    assign s1_adv      = r_s1_valid && !(r_head_valid && r_skid_valid);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign pop         = r_head_valid && !i_out_stall;
    assign push        = s1_adv && r_s1.has_out;
    assign o_out_valid = r_head_valid;
    assign o_out_data  = r_head;

    // Input pixel; drain transactions and pixels past the frame count as black zero pixels.
    assign in_frame = r_in_row < IN_ROW_W'(r_eff_h);
    assign pix      = (!i_in_data.op && in_frame)
                      ? {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in} : '0;
    assign bot      = (pix[CH_W-1:0] == '0);

    // A result is due once one row plus one pixel has gone in.
    assign has_out = (r_in_row > IN_ROW_W'(1))
                     || ((r_in_row == IN_ROW_W'(1)) && (r_in_col != '0));

    // Frame borders around the pixel whose result this transaction releases.
    assign edges.top    = (r_out_row == '0);
    assign edges.bottom = (CFG_HEIGHT_W'(r_out_row) + CFG_HEIGHT_W'(1)) == r_eff_h;
    assign edges.left   = (r_out_col == '0);
    assign edges.right  = (CFG_WIDTH_W'(r_out_col) + CFG_WIDTH_W'(1)) == r_eff_w;
    assign out_last     = edges.bottom && edges.right;
    assign in_col_wrap  = (CFG_WIDTH_W'(r_in_col) + CFG_WIDTH_W'(1)) == r_eff_w;

    // Next values of the position counters and of the memory stage.
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (in_acc) begin
            if (has_out && out_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (in_col_wrap) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + IN_ROW_W'(1);
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
                if (has_out) begin
                    if (edges.right) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + ROW_W'(1);
                    end else begin
                        n_out_col = r_out_col + COL_W'(1);
                    end
                end
            end
        end
        if (in_acc) begin
            n_s1_valid    = 1'b1;
            n_s1.has_out  = has_out;
            n_s1.last     = out_last;
            n_s1.bot      = bot;
            n_s1.edges    = edges;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // Line of pixels one row back, read and overwritten at the same column.
    bbe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_in_col),
        .i_wdata (pix),
        .i_re    (in_acc),
        .i_raddr (r_in_col),
        .o_rdata (row_rdata)
    );

    // Black bits of two rows, split by row parity; the entry read holds the row two back.
    bbe_ram #(
        .WIDTH (1),
        .DEPTH (BLK_DEPTH)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr ({r_in_row[0], r_in_col}),
        .i_wdata (bot),
        .i_re    (in_acc),
        .i_raddr ({r_in_row[0], r_in_col}),
        .o_rdata (blk_rdata)
    );

    // New window column from the memory reads and the incoming pixel.
    assign new_col.blk = {r_s1.bot, (row_rdata[CH_W-1:0] == '0), blk_rdata[0]};
    assign new_col.pix = row_rdata;

    // The window empties after the last result of a frame and on a register write.
    assign win_clear = cfg_wr || (s1_adv && r_s1.has_out && r_s1.last);

    bbe_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_adv),
        .i_clear (win_clear),
        .i_col   (new_col),
        .i_edges (r_s1.edges),
        .o_pix   (win_pix)
    );

    assign push_item.blue_out  = win_pix[CH_W-1:0];
    assign push_item.green_out = win_pix[2*CH_W-1:CH_W];
    assign push_item.red_out   = win_pix[PIX_W-1:2*CH_W];
    assign push_item.frame_end = r_s1.last;

    // Output buffer occupancy: the skid entry refills the head when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_head_valid || pop) begin
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= push;
            end else begin
                r_head_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (!r_head_valid || pop) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                if (push) begin
                    r_skid <= push_item;
                end
            end else if (push) begin
                r_head <= push_item;
            end
        end else if (push) begin
            r_skid <= push_item;
        end
    end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the 3x3 binary boundary extraction block.
`timescale 1ns / 1ps

module tb_top;
    import bbe_pkg::*;

    // Input operation codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Run shaping and end-of-run limits; the hold, tail and settle limits are in clock cycles.
    localparam int unsigned RANDOM_ITEMS = 260;
    localparam int unsigned IDLE_PCT     = 31;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned SETTLE_LIMIT = 20000;
    localparam int unsigned DIR_ROWS     = 23;

    // Directed stimulus rows: either a pixel transaction or a register write.
    typedef enum logic [0:0] {
        ROW_PIXEL,
        ROW_WRITE
    } t_row_kind;

    // Where the expected result of a pixel row comes from.
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_GIVEN
    } t_exp_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_in_item              item;
        t_reg_idx              reg_sel;
        logic [APB_DATA_W-1:0] value;
        t_exp_kind             how;
        t_out_item             want;
    } t_stim_row;

    // Clock, reset and the signals around the block.
    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shared run control and bookkeeping.
    bit          no_idle;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned frames_done;
    int unsigned writes_done;
    int unsigned whitened;
    int unsigned holds_done;
    t_out_item   expected_pixels [$];
    t_out_item   mon_want;

    // Boundary predictor state: registers, line stores, window and counters.
    logic [CFG_WIDTH_W-1:0]  reg_width;
    logic [CFG_HEIGHT_W-1:0] reg_height;
    logic [PIX_W-1:0]        row_pix [MAX_WIDTH];
    bit                      upper_blk [MAX_WIDTH];
    bit [8:0]                win;
    logic [PIX_W-1:0]        ctr_pipe [2];
    int unsigned             col_pos;
    int unsigned             row_pos;
    int unsigned             out_cnt;

    // Directed part: reset geometry, a 3x3 frame with a drain inside the frame and a pixel
    // after frame end, then a 1x1 frame set by zero-valued registers.
    t_stim_row dir_tab [DIR_ROWS] = '{
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_DRAIN, 8'h00, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_WRITE, '0, REG_IMAGE_WIDTH,  32'd3, EXP_NONE, '0},
        '{ROW_WRITE, '0, REG_IMAGE_HEIGHT, 32'd3, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'hFF, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'hFF, 8'hFF}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'h12, 8'h34}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'h56, 8'h78}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_GIVEN,
          '{8'hFF, 8'h00, 8'h00, 1'b0}},
        '{ROW_PIXEL, '{OP_DRAIN, 8'hFF, 8'hFF, 8'hFF}, REG_IMAGE_WIDTH, 32'd0, EXP_MODEL, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'hAA, 8'h55}, REG_IMAGE_WIDTH, 32'd0, EXP_MODEL, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h01, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_MODEL, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'h80, 8'h01}, REG_IMAGE_WIDTH, 32'd0, EXP_MODEL, '0},
        '{ROW_PIXEL, '{OP_DRAIN, 8'h00, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_MODEL, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF}, REG_IMAGE_WIDTH, 32'd0, EXP_MODEL, '0},
        '{ROW_PIXEL, '{OP_DRAIN, 8'h80, 8'h40, 8'h20}, REG_IMAGE_WIDTH, 32'd0, EXP_GIVEN,
          '{8'h01, 8'h00, 8'h00, 1'b0}},
        '{ROW_PIXEL, '{OP_DRAIN, 8'h00, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_MODEL, '0},
        '{ROW_WRITE, '0, REG_IMAGE_WIDTH,  32'd0, EXP_NONE, '0},
        '{ROW_WRITE, '0, REG_IMAGE_HEIGHT, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_PIXEL, 8'h00, 8'hFF, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_DRAIN, 8'h00, 8'h00, 8'h00}, REG_IMAGE_WIDTH, 32'd0, EXP_NONE, '0},
        '{ROW_PIXEL, '{OP_DRAIN, 8'hFF, 8'hFF, 8'hFF}, REG_IMAGE_WIDTH, 32'd0, EXP_GIVEN,
          '{8'hFF, 8'hFF, 8'hFF, 1'b1}}
    };

    binary_boundary_extract_3x3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Every mismatch goes through here: one line printed and one more in the count.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Effective frame size after the register values are clamped into range.
    function automatic int unsigned frame_w();
        if (reg_width == 0) return 1;
        if (reg_width > MAX_WIDTH) return MAX_WIDTH;
        return reg_width;
    endfunction

    function automatic int unsigned frame_h();
        if (reg_height == 0) return 1;
        if (reg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return reg_height;
    endfunction

    // A new frame starts with clear counters, window and pipe; line stores are kept.
    function automatic void restart_frame();
        win         = '0;
        ctr_pipe[0] = '0;
        ctr_pipe[1] = '0;
        col_pos     = 0;
        row_pos     = 0;
        out_cnt     = 0;
    endfunction

    function automatic void boundary_config(input t_reg_idx idx, input logic [31:0] v);
        case (idx)
            REG_IMAGE_WIDTH: begin
                reg_width = v[CFG_WIDTH_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
                reg_height = v[CFG_HEIGHT_W-1:0];
            end
            default: begin
            end
        endcase
        restart_frame();
    endfunction

    // Advances the predictor by one accepted transaction; returns 1 when a result is due.
    function automatic bit boundary_step(input t_in_item it, output t_out_item res);
        int unsigned      w, h, total, k, col, r, c, hits, dr, dc;
        logic [PIX_W-1:0] pix, old_pix, ctr;
        bit               top_b, mid_b, bot_b, last;
        w     = frame_w();
        h     = frame_h();
        total = w * h;
        k     = row_pos * w + col_pos;
        col   = col_pos % MAX_WIDTH;
        res   = '0;
        pix   = '0;
        // Drains, and anything past the frame, enter as black zero pixels.
        if (it.op == OP_PIXEL && k < total) begin
            pix = {it.red_in, it.green_in, it.blue_in};
        end
        bot_b          = (pix[CH_W-1:0] == 0);
        old_pix        = row_pix[col];
        top_b          = upper_blk[col];
        mid_b          = (old_pix[CH_W-1:0] == 0);
        upper_blk[col] = mid_b;
        row_pix[col]   = pix;
        ctr_pipe[1]    = ctr_pipe[0];
        ctr_pipe[0]    = old_pix;
        win = ((win >> 1) & 9'h0DB) | (9'(top_b) << 2) | (9'(mid_b) << 5) | (9'(bot_b) << 8);
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (k < w + 1 || out_cnt >= total) return 1'b0;

        // Count black neighbours, with positions outside the frame counting as black.
        r    = out_cnt / w;
        c    = out_cnt % w;
        ctr  = ctr_pipe[1];
        hits = 0;
        for (dr = 0; dr < 3; dr++) begin
            for (dc = 0; dc < 3; dc++) begin
                if ((dr == 0 && r == 0) || (dr == 2 && r + 1 >= h) ||
                    (dc == 0 && c == 0) || (dc == 2 && c + 1 >= w) || win[dr * 3 + dc]) begin
                    hits++;
                end
            end
        end
        if (hits == 9) begin
            ctr = WHITE_PIX;
            whitened++;
        end
        last          = (out_cnt + 1 == total);
        res.blue_out  = ctr[CH_W-1:0];
        res.green_out = ctr[2*CH_W-1:CH_W];
        res.red_out   = ctr[3*CH_W-1:2*CH_W];
        res.frame_end = last;
        out_cnt++;
        if (last) restart_frame();
        return 1'b1;
    endfunction

    // One APB transfer: setup, access, then an idle state with psel low so that back-to-back calls are clean.
    task automatic apb_access(input bit wr, input t_reg_idx idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_readback(input t_reg_idx idx);
        logic [31:0] got, want;
        apb_access(1'b0, idx, '0, got);
        want = (idx == REG_IMAGE_WIDTH) ? 32'(reg_width) : 32'(reg_height);
        if (got !== want) begin
            report_mismatch($sformatf("register %s reads %0h, expected %0h", idx.name(), got,
                                      want));
        end
    endtask

    // Waits until every expected result has come out, then lets the pipeline run dry.
    task automatic settle();
        int unsigned guard;
        in_valid <= 1'b0;
        guard = 0;
        while (expected_pixels.size() != 0 && guard < SETTLE_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_pixels.size()));
            expected_pixels.delete();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle, and are read back at once.
    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] v);
        logic [31:0] unused;
        settle();
        apb_access(1'b1, idx, v, unused);
        boundary_config(idx, v);
        writes_done++;
        check_readback(idx);
    endtask

    task automatic set_geometry(input int unsigned wv, input int unsigned hv, input bit dirty);
        logic [31:0] junk;
        junk = dirty ? 32'($urandom) : '0;
        cfg_write(REG_IMAGE_WIDTH, (junk << CFG_WIDTH_W) | 32'(wv));
        cfg_write(REG_IMAGE_HEIGHT, (junk << CFG_HEIGHT_W) | 32'(hv));
    endtask

    // Offers one input transaction with random gaps and records what it should release.
    task automatic offer(input t_in_item it, input t_exp_kind how, input t_out_item given);
        t_out_item res;
        bit        has;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        has = boundary_step(it, res);
        if (how == EXP_GIVEN) begin
            expected_pixels.push_back(given);
        end else if (how == EXP_MODEL && has) begin
            expected_pixels.push_back(res);
        end
        items_sent++;
    endtask

    // Sends a frame body of mostly black pixels, then the drain that flushes it if asked.
    task automatic run_frame(input int unsigned pixels, input bit with_drain,
                             input int unsigned density);
        t_in_item    it;
        int unsigned n, span;
        span = pixels + (with_drain ? frame_w() + 1 : 0);
        for (n = 0; n < span; n++) begin
            if (n < pixels) begin
                it.op = ($urandom_range(99) < 4) ? OP_DRAIN : OP_PIXEL;
            end else begin
                it.op = ($urandom_range(99) < 85) ? OP_DRAIN : OP_PIXEL;
            end
            it.blue_in  = ($urandom_range(99) < density) ? 8'h00 : 8'($urandom_range(255, 1));
            it.green_in = 8'($urandom);
            it.red_in   = 8'($urandom);
            offer(it, EXP_MODEL, '0);
        end
    endtask

    // Receiver: random stalls, a quiet stretch, and a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                mon_want = expected_pixels.pop_front();
                if (out_item.blue_out !== mon_want.blue_out)
                    report_mismatch($sformatf("result %0d blue_out %h, expected %h",
                                              results_seen, out_item.blue_out,
                                              mon_want.blue_out));
                if (out_item.green_out !== mon_want.green_out)
                    report_mismatch($sformatf("result %0d green_out %h, expected %h",
                                              results_seen, out_item.green_out,
                                              mon_want.green_out));
                if (out_item.red_out !== mon_want.red_out)
                    report_mismatch($sformatf("result %0d red_out %h, expected %h",
                                              results_seen, out_item.red_out,
                                              mon_want.red_out));
                if (out_item.frame_end !== mon_want.frame_end)
                    report_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                              results_seen, out_item.frame_end,
                                              mon_want.frame_end));
                if (mon_want.frame_end) frames_done++;
            end
        end
    end

    // Main sequence.
    initial begin
        int unsigned i, f, nfr, wv, hv, density, random_end;
        // Predictor starts from the reset state of the block.
        reg_width  = RESET_WIDTH;
        reg_height = RESET_HEIGHT;
        for (i = 0; i < MAX_WIDTH; i++) begin
            row_pix[i]   = '0;
            upper_blk[i] = 1'b0;
        end
        restart_frame();

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        check_readback(REG_IMAGE_WIDTH);
        check_readback(REG_IMAGE_HEIGHT);

        // Directed table.
        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].kind == ROW_WRITE) begin
                cfg_write(dir_tab[i].reg_sel, dir_tab[i].value);
            end else begin
                offer(dir_tab[i].item, dir_tab[i].how, dir_tab[i].want);
            end
        end

        // Random small frames, some cut short, with occasional out-of-range registers.
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            f  = $urandom_range(9);
            wv = (f == 0) ? 0 : (f == 1) ? $urandom_range(20, 13) : $urandom_range(12, 1);
            f  = $urandom_range(9);
            hv = (f == 0) ? 0 : (f == 1) ? $urandom_range(12, 9) : $urandom_range(8, 1);
            set_geometry(wv, hv, $urandom_range(3) == 0);
            nfr = $urandom_range(3, 1);
            for (f = 0; f < nfr && items_sent < random_end; f++) begin
                density = $urandom_range(97, 50);
                if ($urandom_range(7) == 0) begin
                    run_frame($urandom_range(frame_w() * frame_h() - 1, 0), 1'b0, density);
                    break;
                end
                run_frame(frame_w() * frame_h(), 1'b1, density);
            end
        end

        // Reset geometry, left unfinished so the next write restarts it.
        set_geometry(640, 480, 1'b0);
        run_frame(40, 1'b0, 90);

        // Registers above the limits are clamped; short partial frames run through them.
        set_geometry(2047, 1, 1'b1);
        run_frame(30, 1'b0, 92);
        set_geometry(1, 8191, 1'b1);
        run_frame(30, 1'b0, 92);

        // A whole frame with no idling on either side.
        no_idle = 1'b1;
        set_geometry(24, 3, 1'b0);
        run_frame(frame_w() * frame_h(), 1'b1, 92);
        no_idle = 1'b0;

        // Receiver holds off while the sender keeps offering, so the block backs up.
        set_geometry(20, 10, 1'b0);
        hold_req = 1'b1;
        run_frame(frame_w() * frame_h(), 1'b1, 90);

        settle();
        $display("Run covered %0d input transactions and %0d register writes; %0d results checked",
                 items_sent, writes_done, results_seen);
        $display("over %0d complete frames, %0d interior pixels whitened, %0d receiver hold-offs.",
                 frames_done, whitened, holds_done);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
